// ===== sv/cbmt_pkg.sv =====
`default_nettype none
package cbmt_pkg;

  localparam int unsigned VOLT_W     = 16;
  localparam int unsigned CELL_NUM_W = 3;
  localparam int unsigned MASK_W     = 8;
  localparam int unsigned MAX_ACTIVE = 8;
  localparam int unsigned S_TDATA_W  = 24;
  localparam int unsigned M_TDATA_W  = 32;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;

  localparam logic [APB_AW-1:0] ADDR_THRESHOLD = 3'd0;
  localparam logic [VOLT_W-1:0] THRESHOLD_RST  = 16'd120;

endpackage
`default_nettype wire

// ===== sv/cell_balance_min_threshold.sv =====
// Passive cell balancing on windowed cell means.
//
// Slave stream: one cell voltage sample per transfer, tlast marks the last
// sample of a measurement round. Master stream: one balance decision per
// round (discharge mask, lowest cell, lowest mean). APB port: register 0 at
// address 0 holds the 16-bit balance threshold (reset 120).
//
// Each sample reads the oldest slot of its cell's window from a RAM and
// updates the running sum in state ST_RD, then a multiply by the reciprocal
// of WINDOW gives the truncated mean in ST_DIV. An in-range sample holds
// s_axis_tready low through ST_RD and ST_DIV after its transfer, so the next
// sample is taken only after its mean is written; out-of-range samples
// leave s_axis_tready high unless they end the round. A round-end sample
// adds a minimum scan and a mask scan over the active cells, one cell per
// cycle, then ST_OUT moves the decision into the output register.
//
// The decision waits in the output register while the next samples are taken
// in; a second decision waits until the first transfer is done. Reset clears
// windows (by per-cell fill flags), sums and means and loads the threshold.
`default_nettype none
module cell_balance_min_threshold
  import cbmt_pkg::*;
#(
  parameter int unsigned CELLS  = 8,
  parameter int unsigned WINDOW = 8
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // cell_number [2:0], cell_voltage [18:3], zero [23:19]
  input  wire  [S_TDATA_W-1:0]  s_axis_tdata,
  input  wire                   s_axis_tlast,
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  // discharge_mask [7:0], lowest_cell [10:8], lowest_mean [26:11], zero [31:27]
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [APB_AW-1:0]     paddr,
  input  wire  [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready
);

  localparam int unsigned ACTIVE   = (CELLS < MAX_ACTIVE) ? CELLS : MAX_ACTIVE;
  localparam int unsigned CW       = $clog2(ACTIVE);
  localparam int unsigned PW       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned AW       = CW + PW;
  localparam int unsigned RAM_D    = 2 ** AW;
  localparam int unsigned TOTAL_W  = VOLT_W + $clog2(WINDOW);
  localparam int unsigned RECIP_SH = TOTAL_W + $clog2(WINDOW);
  localparam int unsigned RECIP_W  = TOTAL_W + 1;
  localparam int unsigned PROD_W   = TOTAL_W + RECIP_W;
  localparam longint unsigned RECIP = ((64'd1 << RECIP_SH) + WINDOW - 1) / WINDOW;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RD   = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_MIN  = 6'b001000,
    ST_MASK = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [VOLT_W-1:0]  thr_q;
  logic [PW-1:0]      pos_q    [ACTIVE];
  logic               filled_q [ACTIVE];
  logic [TOTAL_W-1:0] total_q  [ACTIVE];
  logic [VOLT_W-1:0]  mean_q   [ACTIVE];

  logic [CW-1:0]      cell_q, cell_d;
  logic [VOLT_W-1:0]  volt_q, volt_d;
  logic               last_q, last_d;
  logic [TOTAL_W-1:0] dq_q, dq_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [VOLT_W-1:0]  low_mean_q, low_mean_d;
  logic [CW-1:0]      low_cell_q, low_cell_d;
  logic [ACTIVE-1:0]  mask_q, mask_d;
  logic               m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;

  logic [S_TDATA_W-1:0] unused_pad;
  logic [CELL_NUM_W-1:0] in_cell;
  logic [VOLT_W-1:0]  in_volt;
  logic               in_range;
  logic               s_acc;
  logic               cfg_wr;

  logic [AW-1:0]      ram_raddr;
  logic [AW-1:0]      ram_waddr;
  logic               ram_we;
  logic [VOLT_W-1:0]  ram_rdata;

  logic [VOLT_W-1:0]  old_sample;
  logic [TOTAL_W-1:0] new_total;
  logic [PROD_W-1:0]  mean_prod;
  logic [VOLT_W-1:0]  mean_next;
  logic [VOLT_W-1:0]  scan_mean;
  logic [VOLT_W-1:0]  diff;
  logic               wr_total;
  logic               wr_mean;
  logic               idx_last;

  assign unused_pad = s_axis_tdata;
  assign in_cell  = s_axis_tdata[CELL_NUM_W-1:0];
  assign in_volt  = s_axis_tdata[CELL_NUM_W +: VOLT_W];
  assign in_range = ({1'b0, in_cell} < (CELL_NUM_W+1)'(ACTIVE));
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc    = s_axis_tvalid && s_axis_tready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_THRESHOLD);
  assign prdata = (paddr == ADDR_THRESHOLD) ? APB_DW'(thr_q) : '0;

  assign ram_raddr = {in_cell[CW-1:0], pos_q[in_cell[CW-1:0]]};
  assign ram_waddr = {cell_q, pos_q[cell_q]};
  assign ram_we    = (state_q == ST_RD);

  cbmt_ram #(
    .WIDTH(VOLT_W),
    .DEPTH(RAM_D)
  ) u_window_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(volt_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // slot not yet written since reset reads as zero
  assign old_sample = filled_q[cell_q] ? ram_rdata : '0;
  assign new_total  = total_q[cell_q] - TOTAL_W'(old_sample) + TOTAL_W'(volt_q);

  // divide by WINDOW: multiply by the rounded-up reciprocal, exact for every sum
  assign mean_prod = PROD_W'(dq_q) * PROD_W'(RECIP);
  assign mean_next = mean_prod[RECIP_SH +: VOLT_W];

  assign scan_mean = mean_q[idx_q];
  assign diff      = scan_mean - low_mean_q;
  assign idx_last  = (idx_q == CW'(ACTIVE - 1));

  always_comb begin
    state_d    = state_q;
    cell_d     = cell_q;
    volt_d     = volt_q;
    last_d     = last_q;
    dq_d       = dq_q;
    idx_d      = idx_q;
    low_mean_d = low_mean_q;
    low_cell_d = low_cell_q;
    mask_d     = mask_q;
    m_data_d   = m_data_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    wr_total   = 1'b0;
    wr_mean    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          cell_d     = in_cell[CW-1:0];
          volt_d     = in_volt;
          last_d     = s_axis_tlast;
          idx_d      = '0;
          low_mean_d = '1;
          low_cell_d = '0;
          if (in_range) begin
            state_d = ST_RD;
          end else if (s_axis_tlast) begin
            state_d = ST_MIN;
          end
        end
      end
      ST_RD: begin
        wr_total = 1'b1;
        dq_d     = new_total;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        wr_mean = 1'b1;
        state_d = last_q ? ST_MIN : ST_IDLE;
      end
      ST_MIN: begin
        if (scan_mean <= low_mean_q) begin
          low_mean_d = scan_mean;
          low_cell_d = idx_q;
        end
        if (idx_last) begin
          idx_d   = '0;
          mask_d  = '0;
          state_d = ST_MASK;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_MASK: begin
        if (diff > thr_q) begin
          mask_d[idx_q] = 1'b1;
        end
        if (idx_last) begin
          state_d = ST_OUT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = M_TDATA_W'({low_mean_q, CELL_NUM_W'(low_cell_q), MASK_W'(mask_q)});
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      thr_q     <= THRESHOLD_RST;
      for (int i = 0; i < ACTIVE; i++) begin
        pos_q[i]    <= '0;
        filled_q[i] <= 1'b0;
        total_q[i]  <= '0;
        mean_q[i]   <= '0;
      end
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (cfg_wr) begin
        thr_q <= pwdata[VOLT_W-1:0];
      end
      if (wr_total) begin
        total_q[cell_q] <= new_total;
        if (pos_q[cell_q] == PW'(WINDOW - 1)) begin
          pos_q[cell_q]    <= '0;
          filled_q[cell_q] <= 1'b1;
        end else begin
          pos_q[cell_q] <= pos_q[cell_q] + 1'b1;
        end
      end
      if (wr_mean) begin
        mean_q[cell_q] <= mean_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q     <= cell_d;
    volt_q     <= volt_d;
    last_q     <= last_d;
    dq_q       <= dq_d;
    idx_q      <= idx_d;
    low_mean_q <= low_mean_d;
    low_cell_q <= low_cell_d;
    mask_q     <= mask_d;
    m_data_q   <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
`default_nettype wire

// ===== sv/cbmt_ram.sv =====
`default_nettype none
module cbmt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/cbmt_checker.sv =====
`default_nettype none
module cbmt_checker
  import cbmt_pkg::*;
#(
  parameter int unsigned CELLS = 8
) (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire [S_TDATA_W-1:0]  s_axis_tdata,
  input wire                  s_axis_tvalid,
  input wire                  s_axis_tready,
  input wire [M_TDATA_W-1:0]  m_axis_tdata,
  input wire                  m_axis_tvalid,
  input wire                  m_axis_tready
);

  localparam int unsigned ACTIVE = (CELLS < MAX_ACTIVE) ? CELLS : MAX_ACTIVE;

  logic [MASK_W-1:0]     out_mask;
  logic [CELL_NUM_W-1:0] out_cell;
  logic                  in_range;
  logic                  high_bits_zero;
  logic                  cell_active;

  assign out_mask = m_axis_tdata[MASK_W-1:0];
  assign out_cell = m_axis_tdata[MASK_W +: CELL_NUM_W];
  assign in_range = ({1'b0, s_axis_tdata[CELL_NUM_W-1:0]} < (CELL_NUM_W+1)'(ACTIVE));
  assign high_bits_zero = ((out_mask >> ACTIVE) == '0);
  assign cell_active = ({1'b0, out_cell} < (CELL_NUM_W+1)'(ACTIVE));

  a_reset_no_output: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  a_output_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_busy_after_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && in_range |=> !s_axis_tready)
    else $error("ready while a sample is in work");

  a_lowest_not_discharged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !out_mask[out_cell])
    else $error("lowest cell marked for discharge");

  a_mask_active_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> high_bits_zero && cell_active)
    else $error("result names an inactive cell");

endmodule

bind cell_balance_min_threshold cbmt_checker #(.CELLS(CELLS)) u_cbmt_checker (.*);
`default_nettype wire
